/* rtl/core/skrt_pkg.sv */
// ----------------------------------------------------------------------------
// skrt_pkg
// shared types and constants for the sorted keyed row table
// ----------------------------------------------------------------------------
package skrt_pkg;

    localparam int ACTION_W  = 2;
    localparam int KEY_IN_W  = 16;
    localparam int DATA_W    = 32;
    localparam int STATUS_W  = 3;
    localparam int CFG_W     = 5;
    localparam logic [CFG_W-1:0] CFG_RESET = 5'd16;

    typedef enum logic [ACTION_W-1:0] {
        ACT_INSERT = 2'd0,
        ACT_LOOKUP = 2'd1,
        ACT_CLEAR  = 2'd2
    } action_t;

    typedef enum logic [STATUS_W-1:0] {
        STS_INSERTED  = 3'd0,
        STS_DUPLICATE = 3'd1,
        STS_HIT       = 3'd2,
        STS_MISS      = 3'd3,
        STS_CLEARED   = 3'd4
    } status_t;

    typedef enum logic [1:0] {
        S_IDLE  = 2'd0,
        S_SCAN  = 2'd1,
        S_SHIFT = 2'd2,
        S_DONE  = 2'd3
    } state_t;

    typedef struct packed {
        logic    op_load;
        logic    rd_en;
        logic    rd_next;
        logic    idx_inc;
        logic    wr_en;
        logic    wr_new;
        logic    valid_clr;
        logic    res_load;
        status_t res_status;
        logic    res_hit;
    } cmd_t;

    typedef struct packed {
        logic [ACTION_W-1:0] action;
        logic                n_zero;
        logic                last;
        logic                rd_valid;
        logic                key_eq;
        logic                key_gt;
    } sts_t;

endpackage

/* rtl/core/sorted_keyed_row_table.sv */
// ----------------------------------------------------------------------------
// sorted_keyed_row_table
// key/value table kept in ascending key order, with insert, lookup and clear
// ----------------------------------------------------------------------------
//  channel   handshake             payload
//  ------    ---------             -------
//  input     in_valid / in_ready   action, key, value
//  output    out_valid / out_ready status, found_value
//  config    cfg_write             cfg_data (slots_in_use)
//
//  an insert or lookup walks k slots, k from 0 to slots_in_use
//  the walk visits one entry per cycle through the single read port of the entry memory
//  clear and unknown actions skip the walk and go straight to the result
//  reset empties the table at once and sets slots_in_use to 16
//  a finished result waits in the output register while the next beat is taken
// ----------------------------------------------------------------------------
module sorted_keyed_row_table import skrt_pkg::*; #(
    parameter int SLOTS     = 16,
    parameter int KEY_WIDTH = 16
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     cfg_write,
    input  logic [CFG_W-1:0]         cfg_data,
    input  logic                     in_valid,
    output logic                     in_ready,
    input  logic [ACTION_W-1:0]      action,
    input  logic [KEY_IN_W-1:0]      key,
    input  logic signed [DATA_W-1:0] value,
    output logic                     out_valid,
    input  logic                     out_ready,
    output logic [STATUS_W-1:0]      status,
    output logic signed [DATA_W-1:0] found_value
);

    cmd_t cmd;
    sts_t sts;

    skrt_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .action    (action),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .sts       (sts),
        .cmd       (cmd)
    );

    skrt_datapath #(
        .SLOTS     (SLOTS),
        .KEY_WIDTH (KEY_WIDTH)
    ) u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_write   (cfg_write),
        .cfg_data    (cfg_data),
        .action      (action),
        .key         (key),
        .value       (value),
        .cmd         (cmd),
        .sts         (sts),
        .status      (status),
        .found_value (found_value)
    );

endmodule

/* rtl/core/skrt_datapath.sv */
// ----------------------------------------------------------------------------
// skrt_datapath
// entry memory, valid bits, scan index, carry stage and result register
// ----------------------------------------------------------------------------
module skrt_datapath import skrt_pkg::*; #(
    parameter int SLOTS     = 16,
    parameter int KEY_WIDTH = 16
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_write,
    input  logic [CFG_W-1:0]           cfg_data,
    input  logic [ACTION_W-1:0]        action,
    input  logic [KEY_IN_W-1:0]        key,
    input  logic signed [DATA_W-1:0]   value,
    input  cmd_t                       cmd,
    output sts_t                       sts,
    output logic [STATUS_W-1:0]        status,
    output logic signed [DATA_W-1:0]   found_value
);

    localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CNT_W = $clog2(SLOTS + 1);

    logic [KEY_WIDTH-1:0] key_mem [SLOTS];
    logic [DATA_W-1:0]    data_mem [SLOTS];

    logic [SLOTS-1:0]     valid_reg;
    logic [CFG_W-1:0]     cfg_reg;
    logic [IDX_W-1:0]     idx_reg;
    logic [ACTION_W-1:0]  op_action_reg;
    logic [KEY_WIDTH-1:0] op_key_reg;
    logic [DATA_W-1:0]    op_value_reg;
    logic                 rd_valid_reg;
    logic [KEY_WIDTH-1:0] rd_key_reg;
    logic [DATA_W-1:0]    rd_data_reg;
    logic                 carry_valid_reg;
    logic [KEY_WIDTH-1:0] carry_key_reg;
    logic [DATA_W-1:0]    carry_data_reg;
    logic [STATUS_W-1:0]  status_reg;
    logic [DATA_W-1:0]    found_reg;

    logic [CNT_W-1:0]     n_act;
    logic [IDX_W-1:0]     rd_addr;
    logic [KEY_WIDTH-1:0] wr_key;
    logic [DATA_W-1:0]    wr_data;
    logic                 wr_valid;

    always_comb
    begin
        if (int'(cfg_reg) > SLOTS)
        begin
            n_act = CNT_W'(SLOTS);
        end
        else
        begin
            n_act = CNT_W'(cfg_reg);
        end
    end

    assign rd_addr  = cmd.rd_next ? (idx_reg + IDX_W'(1)) : '0;
    assign wr_key   = cmd.wr_new ? op_key_reg   : carry_key_reg;
    assign wr_data  = cmd.wr_new ? op_value_reg : carry_data_reg;
    assign wr_valid = cmd.wr_new ? 1'b1         : carry_valid_reg;

    assign sts.action   = op_action_reg;
    assign sts.n_zero   = (n_act == '0);
    assign sts.last     = ((CNT_W'(idx_reg) + CNT_W'(1)) == n_act);
    assign sts.rd_valid = rd_valid_reg;
    assign sts.key_eq   = (rd_key_reg == op_key_reg);
    assign sts.key_gt   = (op_key_reg > rd_key_reg);

    assign status      = status_reg;
    assign found_value = signed'(found_reg);

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            cfg_reg   <= CFG_RESET;
            idx_reg   <= '0;
        end
        else
        begin
            if (cfg_write)
            begin
                cfg_reg <= cfg_data;
            end
            if (cmd.valid_clr)
            begin
                valid_reg <= '0;
            end
            else if (cmd.wr_en)
            begin
                valid_reg[idx_reg] <= wr_valid;
            end
            if (cmd.op_load)
            begin
                idx_reg <= '0;
            end
            else if (cmd.idx_inc)
            begin
                idx_reg <= idx_reg + IDX_W'(1);
            end
        end
    end

    // entry memory, one write and one registered read per cycle
    always_ff @(posedge clk)
    begin
        if (cmd.wr_en)
        begin
            key_mem[idx_reg]  <= wr_key;
            data_mem[idx_reg] <= wr_data;
        end
        if (cmd.rd_en)
        begin
            rd_key_reg   <= key_mem[rd_addr];
            rd_data_reg  <= data_mem[rd_addr];
            rd_valid_reg <= valid_reg[rd_addr];
        end
    end

    // operand, carry and result payload
    always_ff @(posedge clk)
    begin
        if (cmd.op_load)
        begin
            op_action_reg <= action;
            op_key_reg    <= KEY_WIDTH'(key);
            op_value_reg  <= unsigned'(value);
        end
        if (cmd.wr_en)
        begin
            carry_valid_reg <= rd_valid_reg;
            carry_key_reg   <= rd_key_reg;
            carry_data_reg  <= rd_data_reg;
        end
        if (cmd.res_load)
        begin
            status_reg <= cmd.res_status;
            found_reg  <= cmd.res_hit ? rd_data_reg : '0;
        end
    end

    a_clear_empties: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.valid_clr |=> (valid_reg == '0))
        else $error("valid bits not cleared");

endmodule

/* rtl/core/skrt_ctrl.sv */
// ----------------------------------------------------------------------------
// skrt_ctrl
// sequencer for scan, shift and result hand-off
// ----------------------------------------------------------------------------
module skrt_ctrl import skrt_pkg::*; (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [ACTION_W-1:0] action,
    output logic                out_valid,
    input  logic                out_ready,
    input  sts_t                sts,
    output cmd_t                cmd
);

    state_t  state_reg, state_next;
    status_t pend_status_reg, pend_status_next;
    logic    pend_hit_reg, pend_hit_next;
    logic    out_valid_reg, out_valid_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            pend_status_reg <= STS_MISS;
            pend_hit_reg    <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            pend_status_reg <= pend_status_next;
            pend_hit_reg    <= pend_hit_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;

    always_comb
    begin
        state_next       = state_reg;
        pend_status_next = pend_status_reg;
        pend_hit_next    = pend_hit_reg;
        out_valid_next   = out_valid_reg;
        cmd              = '0;
        cmd.res_status   = pend_status_reg;
        cmd.res_hit      = pend_hit_reg;

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.op_load   = 1'b1;
                    cmd.rd_en     = 1'b1;
                    pend_hit_next = 1'b0;
                    state_next    = S_DONE;
                    unique case (action)
                        ACT_INSERT:
                        begin
                            pend_status_next = STS_INSERTED;
                            if (!sts.n_zero)
                            begin
                                state_next = S_SCAN;
                            end
                        end
                        ACT_LOOKUP:
                        begin
                            pend_status_next = STS_MISS;
                            if (!sts.n_zero)
                            begin
                                state_next = S_SCAN;
                            end
                        end
                        ACT_CLEAR:
                        begin
                            cmd.valid_clr    = 1'b1;
                            pend_status_next = STS_CLEARED;
                        end
                        default:
                        begin
                            pend_status_next = STS_MISS;
                        end
                    endcase
                end
            end
            S_SCAN:
            begin
                if (sts.action == ACT_LOOKUP)
                begin
                    priority if (sts.rd_valid && sts.key_eq)
                    begin
                        pend_status_next = STS_HIT;
                        pend_hit_next    = 1'b1;
                        state_next       = S_DONE;
                    end
                    else if (sts.last)
                    begin
                        pend_status_next = STS_MISS;
                        state_next       = S_DONE;
                    end
                    else
                    begin
                        cmd.idx_inc = 1'b1;
                        cmd.rd_en   = 1'b1;
                        cmd.rd_next = 1'b1;
                    end
                end
                else
                begin
                    priority if (sts.rd_valid && sts.key_gt)
                    begin
                        if (sts.last)
                        begin
                            pend_status_next = STS_INSERTED;
                            state_next       = S_DONE;
                        end
                        else
                        begin
                            cmd.idx_inc = 1'b1;
                            cmd.rd_en   = 1'b1;
                            cmd.rd_next = 1'b1;
                        end
                    end
                    else if (sts.rd_valid && sts.key_eq)
                    begin
                        pend_status_next = STS_DUPLICATE;
                        state_next       = S_DONE;
                    end
                    else
                    begin
                        cmd.wr_en  = 1'b1;
                        cmd.wr_new = 1'b1;
                        if (sts.last)
                        begin
                            pend_status_next = STS_INSERTED;
                            state_next       = S_DONE;
                        end
                        else
                        begin
                            cmd.idx_inc = 1'b1;
                            cmd.rd_en   = 1'b1;
                            cmd.rd_next = 1'b1;
                            state_next  = S_SHIFT;
                        end
                    end
                end
            end
            S_SHIFT:
            begin
                cmd.wr_en = 1'b1;
                if (sts.last)
                begin
                    pend_status_next = STS_INSERTED;
                    state_next       = S_DONE;
                end
                else
                begin
                    cmd.idx_inc = 1'b1;
                    cmd.rd_en   = 1'b1;
                    cmd.rd_next = 1'b1;
                end
            end
            S_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    cmd.res_load   = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    a_load_when_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.res_load |-> (!out_valid_reg || out_ready))
        else $error("result loaded over a pending beat");

    a_write_in_walk: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.wr_en |-> (state_reg == S_SCAN || state_reg == S_SHIFT))
        else $error("entry write outside scan or shift");

    a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> (state_reg != S_IDLE))
        else $error("accepted beat left controller idle");

    a_result_follows_done: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.res_load |=> out_valid_reg)
        else $error("loaded result not presented");

endmodule
